[design/euclidean_rhythm_generator_macros.svh]
`ifndef EUCLIDEAN_RHYTHM_GENERATOR_MACROS_SVH
`define EUCLIDEAN_RHYTHM_GENERATOR_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define ERG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define ERG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/erg_pkg.sv]
`timescale 1ns / 1ps

package erg_pkg;

    // pattern builder sequencer
    typedef enum logic [1:0] {
        BLD_IDLE,
        BLD_DIV,
        BLD_EXP
    } bld_state_t;

    // top level request sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_SRCH,
        ST_EMIT
    } ctl_state_t;

endpackage

[design/euclidean_rhythm_generator.sv]
`timescale 1ns / 1ps
`include "euclidean_rhythm_generator_macros.svh"

// euclidean rhythm generator
// input channel: one beat carries step_count n and pulse_count k; in_stall is
// high from acceptance until the last result of that request is loaded
// output channel: n beats per request, each with the pattern bit (beat), its
// position and last on the final one; a bad request (n = 0, n > MAX_STEPS or
// k > n) gives one beat with bad_request, beat 0, position 0 and last set
// the builder divides by repeated subtraction, level by level, then appends
// one substring per cycle through a single shifter, then searches for the
// first onset one bit a cycle, all before the first result is loaded
// results then leave at one per cycle while out_stall is low
// k = 0 skips the builder: n zero beats follow straight away
// reset clears the sequencers and the output valid; nothing else is kept
// between requests
// a stalled output holds its beat in the output register; the sequencer waits
// and the next request is taken once the final beat is loaded

module euclidean_rhythm_generator #(
    parameter int MAX_STEPS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [6:0] step_count,
    input  logic [6:0] pulse_count,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       beat,
    output logic [5:0] position,
    output logic       last,
    output logic       bad_request
);

    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int PW = $clog2(MAX_STEPS);

    erg_pkg::ctl_state_t state_reg, state_next;

    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] len_reg, len_next;
    logic          bad_reg, bad_next;
    logic [CW-1:0] i_reg, i_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [CW-1:0] sc_reg, sc_next;

    logic       ov_reg, ov_next;
    logic       beat_reg, beat_next;
    logic [5:0] pos_reg, pos_next;
    logic       last_reg, last_next;
    logic       badq_reg, badq_next;

    logic                 bld_start, bld_done;
    logic [MAX_STEPS-1:0] bld_pattern;
    logic [CW-1:0]        bld_len;

    logic          accept, req_bad, load, emit_last, srch_hit;
    logic [CW-1:0] len_m1;

    assign accept  = in_valid && (state_reg == erg_pkg::ST_IDLE);
    assign req_bad = (step_count == 7'd0)
        || (32'(step_count) > 32'(MAX_STEPS))
        || (pulse_count > step_count);
    assign load      = !ov_reg || !out_stall;
    assign emit_last = bad_reg || (i_reg == n_reg - 1'b1);
    assign len_m1    = len_reg - 1'b1;
    assign srch_hit  = bld_pattern[rp_reg] || (sc_reg == len_m1);
    assign bld_start = accept && !req_bad && (pulse_count != 7'd0);

    erg_build #(
        .MAX_STEPS(MAX_STEPS)
    ) u_build (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (bld_start),
        .n      (CW'(step_count)),
        .k      (CW'(pulse_count)),
        .done   (bld_done),
        .pattern(bld_pattern),
        .pat_len(bld_len)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            erg_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = bld_start ? erg_pkg::ST_BUILD : erg_pkg::ST_EMIT;
            end
            erg_pkg::ST_BUILD:
            begin
                if (bld_done)
                    state_next = (bld_len == '0) ? erg_pkg::ST_EMIT : erg_pkg::ST_SRCH;
            end
            erg_pkg::ST_SRCH:
            begin
                if (srch_hit)
                    state_next = erg_pkg::ST_EMIT;
            end
            erg_pkg::ST_EMIT:
            begin
                if (load && emit_last)
                    state_next = erg_pkg::ST_IDLE;
            end
            default:
                state_next = erg_pkg::ST_IDLE;
        endcase
    end

    // datapath and output register
    always_comb
    begin
        n_next    = n_reg;
        len_next  = len_reg;
        bad_next  = bad_reg;
        i_next    = i_reg;
        rp_next   = rp_reg;
        sc_next   = sc_reg;
        ov_next   = load ? 1'b0 : ov_reg;
        beat_next = beat_reg;
        pos_next  = pos_reg;
        last_next = last_reg;
        badq_next = badq_reg;
        case (state_reg)
            erg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    n_next   = CW'(step_count);
                    bad_next = req_bad;
                    len_next = '0;
                    i_next   = '0;
                end
            end
            erg_pkg::ST_BUILD:
            begin
                if (bld_done)
                begin
                    len_next = bld_len;
                    rp_next  = PW'(bld_len - 1'b1);
                    sc_next  = '0;
                end
            end
            erg_pkg::ST_SRCH:
            begin
                // walk the reversed pattern until the first onset
                if (!srch_hit)
                begin
                    rp_next = rp_reg - 1'b1;
                    sc_next = sc_reg + 1'b1;
                end
            end
            erg_pkg::ST_EMIT:
            begin
                if (load)
                begin
                    ov_next   = 1'b1;
                    beat_next = !bad_reg && (i_reg < len_reg) && bld_pattern[rp_reg];
                    pos_next  = bad_reg ? 6'd0 : 6'(i_reg);
                    last_next = emit_last;
                    badq_next = bad_reg;
                    i_next    = i_reg + 1'b1;
                    rp_next   = (rp_reg == '0) ? PW'(len_m1) : rp_reg - 1'b1;
                end
            end
            default:
            begin
                ov_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= erg_pkg::ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        len_reg  <= len_next;
        bad_reg  <= bad_next;
        i_reg    <= i_next;
        rp_reg   <= rp_next;
        sc_reg   <= sc_next;
        beat_reg <= beat_next;
        pos_reg  <= pos_next;
        last_reg <= last_next;
        badq_reg <= badq_next;
    end

    assign in_stall    = (state_reg != erg_pkg::ST_IDLE);
    assign out_valid   = ov_reg;
    assign beat        = beat_reg;
    assign position    = pos_reg;
    assign last        = last_reg;
    assign bad_request = badq_reg;

    `ERG_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
        "input not stalled after a request was taken")
    `ERG_ASSERT_NOW(a_bad_single, out_valid && bad_request,
        last && !beat && (position == 6'd0), "malformed error result")
    `ERG_ASSERT_NOW(a_srch_len, state_reg == erg_pkg::ST_SRCH, len_reg != '0,
        "onset search on an empty pattern")

endmodule

[design/erg_build.sv]
`timescale 1ns / 1ps
`include "euclidean_rhythm_generator_macros.svh"

module erg_build #(
    parameter int MAX_STEPS = 64,
    localparam int CW = $clog2(MAX_STEPS + 1),
    localparam int LD = 2 * $clog2(MAX_STEPS) + 2,
    localparam int LVW = $clog2(LD)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CW-1:0]        n,
    input  logic [CW-1:0]        k,
    output logic                 done,
    output logic [MAX_STEPS-1:0] pattern,
    output logic [CW-1:0]        pat_len
);

    erg_pkg::bld_state_t state_reg, state_next;

    // per-level quotient and remainder lists
    logic [CW-1:0] cnt_mem [LD];
    logic [CW-1:0] rem_mem [LD];

    logic           cnt_we, rem_we;
    logic [LVW-1:0] cnt_waddr, rem_waddr;
    logic [CW-1:0]  cnt_wdata, rem_wdata;

    logic [CW-1:0]        dv_reg, dv_next;
    logic [CW-1:0]        dr_reg, dr_next;
    logic [CW-1:0]        q_reg, q_next;
    logic [LVW-1:0]       lvl_reg, lvl_next;
    logic [LVW-1:0]       lv_reg, lv_next;
    logic [CW-1:0]        rep_reg, rep_next;
    logic [CW-1:0]        top_reg, top_next;
    logic [MAX_STEPS-1:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [CW-1:0]        la_reg, la_next, lb_reg, lb_next, lc_reg, lc_next;
    logic                 done_reg, done_next;

    // shared append unit
    logic [MAX_STEPS-1:0] sh_in, sh_out;
    logic [CW-1:0]        sh_len, lsat;
    logic [CW:0]          lsum;
    logic [CW-1:0]        cur_cnt, cur_rem;
    logic [LVW-1:0]       lvl_inc;
    logic                 div_stop, exp_more, exp_last;

    assign cur_cnt  = (lv_reg == lvl_reg) ? top_reg : cnt_mem[lv_reg];
    assign cur_rem  = rem_mem[lv_reg];
    assign exp_more = (rep_reg < cur_cnt);
    assign exp_last = (lv_reg == lvl_reg);
    assign lvl_inc  = lvl_reg + 1'b1;
    assign div_stop = (dv_reg <= CW'(1))
        || ({1'b0, lvl_inc} >= (LVW + 1)'(LD - 2));

    always_comb
    begin
        if (exp_more)
        begin
            sh_in  = a_reg;
            sh_len = la_reg;
        end
        else if (cur_rem != '0)
        begin
            sh_in  = b_reg;
            sh_len = lb_reg;
        end
        else
        begin
            sh_in  = '0;
            sh_len = '0;
        end
    end

    assign sh_out = c_reg | (sh_in << lc_reg);
    assign lsum   = {1'b0, lc_reg} + {1'b0, sh_len};
    assign lsat   = (lsum > (CW + 1)'(MAX_STEPS)) ? CW'(MAX_STEPS) : lsum[CW-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            erg_pkg::BLD_IDLE:
            begin
                if (start)
                    state_next = erg_pkg::BLD_DIV;
            end
            erg_pkg::BLD_DIV:
            begin
                if (dv_reg < dr_reg && div_stop)
                    state_next = erg_pkg::BLD_EXP;
            end
            erg_pkg::BLD_EXP:
            begin
                if (!exp_more && exp_last)
                    state_next = erg_pkg::BLD_IDLE;
            end
            default:
                state_next = erg_pkg::BLD_IDLE;
        endcase
    end

    // datapath and list writes
    always_comb
    begin
        dv_next   = dv_reg;
        dr_next   = dr_reg;
        q_next    = q_reg;
        lvl_next  = lvl_reg;
        lv_next   = lv_reg;
        rep_next  = rep_reg;
        top_next  = top_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        la_next   = la_reg;
        lb_next   = lb_reg;
        lc_next   = lc_reg;
        done_next = 1'b0;
        cnt_we    = 1'b0;
        cnt_waddr = lvl_reg;
        cnt_wdata = q_reg;
        rem_we    = 1'b0;
        rem_waddr = lvl_inc;
        rem_wdata = dv_reg;
        case (state_reg)
            erg_pkg::BLD_IDLE:
            begin
                if (start)
                begin
                    dv_next   = n - k;
                    dr_next   = k;
                    q_next    = '0;
                    lvl_next  = '0;
                    rem_we    = 1'b1;
                    rem_waddr = '0;
                    rem_wdata = k;
                end
            end
            erg_pkg::BLD_DIV:
            begin
                if (dv_reg >= dr_reg)
                begin
                    dv_next = dv_reg - dr_reg;
                    q_next  = q_reg + 1'b1;
                end
                else
                begin
                    cnt_we   = 1'b1;
                    rem_we   = 1'b1;
                    dr_next  = dv_reg;
                    dv_next  = dr_reg;
                    q_next   = '0;
                    lvl_next = lvl_inc;
                    if (div_stop)
                    begin
                        // top level count is the last divisor
                        top_next = dr_reg;
                        lv_next  = '0;
                        rep_next = '0;
                        a_next   = '0;
                        la_next  = CW'(1);
                        b_next   = MAX_STEPS'(1);
                        lb_next  = CW'(1);
                        c_next   = '0;
                        lc_next  = '0;
                    end
                end
            end
            erg_pkg::BLD_EXP:
            begin
                if (exp_more)
                begin
                    c_next   = sh_out;
                    lc_next  = lsat;
                    rep_next = rep_reg + 1'b1;
                end
                else
                begin
                    b_next   = a_reg;
                    lb_next  = la_reg;
                    a_next   = sh_out;
                    la_next  = lsat;
                    c_next   = '0;
                    lc_next  = '0;
                    rep_next = '0;
                    lv_next  = lv_reg + 1'b1;
                    if (exp_last)
                        done_next = 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= erg_pkg::BLD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_reg  <= dv_next;
        dr_reg  <= dr_next;
        q_reg   <= q_next;
        lvl_reg <= lvl_next;
        lv_reg  <= lv_next;
        rep_reg <= rep_next;
        top_reg <= top_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        la_reg  <= la_next;
        lb_reg  <= lb_next;
        lc_reg  <= lc_next;
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (rem_we)
            rem_mem[rem_waddr] <= rem_wdata;
    end

    assign done    = done_reg;
    assign pattern = a_reg;
    assign pat_len = la_reg;

    `ERG_ASSERT_NOW(a_div_nonzero, state_reg == erg_pkg::BLD_DIV, dr_reg != '0,
        "divisor is zero during division")
    `ERG_ASSERT_NOW(a_exp_level, state_reg == erg_pkg::BLD_EXP, lv_reg <= lvl_reg,
        "expansion level beyond top level")
    `ERG_ASSERT_NEXT(a_done_idle, done_next, state_reg == erg_pkg::BLD_IDLE,
        "done raised while builder still busy")

endmodule

[dv/euclidean_rhythm_generator_test.sv]
`timescale 1ns / 1ps

module euclidean_rhythm_generator_test;

    localparam int MAX_N = 64;
    localparam int N_RANDOM = 440;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [6:0] steps;
        logic [6:0] pulses;
    } request_t;

    typedef struct packed {
        logic       onset;
        logic [5:0] pos;
        logic       fin;
        logic       bad;
    } pulse_beat_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [6:0] step_count;
    logic [6:0] pulse_count;
    logic       out_valid;
    logic       out_stall;
    logic       beat;
    logic [5:0] position;
    logic       last;
    logic       bad_request;

    euclidean_rhythm_generator #(.MAX_STEPS(MAX_N)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .step_count (step_count),
        .pulse_count(pulse_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .beat       (beat),
        .position   (position),
        .last       (last),
        .bad_request(bad_request)
    );

    // clock, 4 ns period
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    request_t    pending_requests[$];
    pulse_beat_t expected_beats[$];
    int          error_count = 0;
    int          requests_sent = 0;
    int          beats_checked = 0;
    int          bad_seen = 0;
    int          idle_cycles = 0;
    bit          hold_send = 0;   // sender pause requested by the stimulus
    bit          long_hold = 0;   // receiver long stall requested
    int          hold_count = 0;

    // bjorklund level tables, one set per request
    int unsigned level_cnt[48];
    int unsigned level_rem[48];
    bit          rhythm[$];

    function automatic void expand_level(int lv);
        if (lv == -1)
            rhythm = {rhythm, 1'b0};
        else if (lv == -2)
            rhythm = {rhythm, 1'b1};
        else if (lv >= 0 && lv < 48)
        begin
            for (int unsigned i = 0; i < level_cnt[lv]; i++)
                expand_level(lv - 1);
            if (level_rem[lv] != 0)
                expand_level(lv - 2);
        end
    endfunction

    // works out the beats one request yields and queues them
    function automatic void predict_rhythm(request_t req);
        int unsigned n;
        int unsigned k;
        int unsigned d;
        int          idx;
        int          first;
        bit          pat[$];
        pulse_beat_t pb;
        n = req.steps;
        k = req.pulses;
        if (n == 0 || n > MAX_N || k > n)
        begin
            pb = '{onset: 1'b0, pos: 6'd0, fin: 1'b1, bad: 1'b1};
            expected_beats = {expected_beats, pb};
            return;
        end
        rhythm.delete();
        for (int i = 0; i < 48; i++)
        begin
            level_cnt[i] = 0;
            level_rem[i] = 0;
        end
        if (k != 0)
        begin
            d = n - k;
            idx = 0;
            level_rem[0] = k;
            forever
            begin
                level_cnt[idx] = d / level_rem[idx];
                level_rem[idx + 1] = d % level_rem[idx];
                d = level_rem[idx];
                idx++;
                if (level_rem[idx] <= 1 || idx >= 46)
                    break;
            end
            level_cnt[idx] = d;
            expand_level(idx);
            while (rhythm.size() > MAX_N)
                void'(rhythm.pop_back());
            // reverse, then rotate so the first bit is an onset
            pat = {};
            for (int i = rhythm.size() - 1; i >= 0; i--)
                pat = {pat, rhythm[i]};
            first = 0;
            while (first < pat.size() && pat[first] == 1'b0)
                first++;
            rhythm = {};
            for (int i = 0; i < pat.size(); i++)
                rhythm = {rhythm, (first < pat.size()) ? pat[(first + i) % pat.size()]
                                                       : pat[i]};
        end
        for (int unsigned i = 0; i < n; i++)
        begin
            pb.onset = (i < rhythm.size()) ? rhythm[i] : 1'b0;
            pb.pos   = i[5:0];
            pb.fin   = (i + 1 == n);
            pb.bad   = 1'b0;
            expected_beats = {expected_beats, pb};
        end
    endfunction

    // driver: bursts of random length, with a random gap after some of them
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            step_count  <= '0;
            pulse_count <= '0;
            burst_left  = 0;
            gap_left    = 0;
        end
        else
        begin
            // the beat on offer is taken at this edge
            if (in_valid && !in_stall)
            begin
                predict_rhythm('{steps: step_count, pulses: pulse_count});
                requests_sent++;
                void'(pending_requests.pop_front());
            end
            if (in_valid && in_stall)
                ; // held payload stays put
            else if (hold_send || pending_requests.size() == 0)
                in_valid <= 1'b0;
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else
            begin
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 8);
                burst_left--;
                if (burst_left == 0 && $urandom_range(0, 2) != 0)
                    gap_left = $urandom_range(1, 40);
                in_valid    <= 1'b1;
                step_count  <= pending_requests[0].steps;
                pulse_count <= pending_requests[0].pulses;
            end
        end
    end

    // receiver stall pattern, with a long hold when asked
    int stall_mode = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            hold_count = 0;
        end
        else if (long_hold)
        begin
            hold_count++;
            out_stall <= (hold_count < 600);
        end
        else
        begin
            if ($urandom_range(0, 99) == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // monitor: compares each result beat with the oldest expectation
    pulse_beat_t want;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected beat: beat %0d position %0d", beat, position);
                    error_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    beats_checked++;
                    if (bad_request)
                        bad_seen++;
                    if (beat !== want.onset)
                    begin
                        $error("beat: expected %0d, got %0d", want.onset, beat);
                        error_count++;
                    end
                    if (position !== want.pos)
                    begin
                        $error("position: expected %0d, got %0d", want.pos, position);
                        error_count++;
                    end
                    if (last !== want.fin)
                    begin
                        $error("last: expected %0d, got %0d", want.fin, last);
                        error_count++;
                    end
                    if (bad_request !== want.bad)
                    begin
                        $error("bad_request: expected %0d, got %0d", want.bad,
                               bad_request);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no progress, %0d beats still expected",
                         expected_beats.size());
                $display("euclidean_rhythm_generator_test: done, errors");
                $finish;
            end
        end
    end

    function automatic void queue_request(int n, int k);
        request_t r;
        r.steps = n[6:0];
        r.pulses = k[6:0];
        pending_requests = {pending_requests, r};
    endfunction

    initial
    begin
        int n;
        int pick;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, no pulses, all pulses, bad requests
        queue_request(1, 0);
        queue_request(1, 1);
        queue_request(64, 0);
        queue_request(64, 64);
        queue_request(64, 1);
        queue_request(64, 63);
        queue_request(8, 3);
        queue_request(16, 5);
        queue_request(13, 5);
        queue_request(12, 7);
        queue_request(2, 1);
        queue_request(3, 2);
        queue_request(0, 0);
        queue_request(0, 127);
        queue_request(65, 1);
        queue_request(127, 127);
        queue_request(5, 6);
        queue_request(64, 65);
        queue_request(1, 2);
        queue_request(63, 32);
        queue_request(64, 21);

        // long receiver hold while requests keep coming
        long_hold = 1;
        for (int i = 0; i < 4; i++)
            queue_request($urandom_range(1, 64), $urandom_range(0, 8));
        wait (hold_count >= 600);
        long_hold = 0;

        // sender pause until every result has been checked
        wait (pending_requests.size() == 0);
        hold_send = 1;
        wait (expected_beats.size() == 0);
        hold_send = 0;

        for (int i = 0; i < N_RANDOM; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                queue_request($urandom_range(0, 127), $urandom_range(0, 127));
            else if (pick == 1)
            begin
                n = $urandom_range(1, 63);
                queue_request(n, $urandom_range(n + 1, 127));
            end
            else if (pick < 5)
            begin
                n = $urandom_range(1, 64);
                queue_request(n, ($urandom_range(0, 1) != 0) ? n : 0);
            end
            else
            begin
                n = (pick < 17) ? $urandom_range(1, 24) : $urandom_range(25, 64);
                queue_request(n, $urandom_range(1, n));
            end
        end

        wait (pending_requests.size() == 0 && !in_valid);
        wait (expected_beats.size() == 0);
        repeat (300) @(posedge clk);

        $display("covered %0d requests, %0d result beats checked, %0d bad requests",
                 requests_sent, beats_checked, bad_seen);
        if (error_count == 0 && expected_beats.size() == 0)
            $display("euclidean_rhythm_generator_test: done, clean");
        else
            $display("euclidean_rhythm_generator_test: done, errors");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/erg_pkg.sv
design/erg_build.sv
design/euclidean_rhythm_generator.sv
dv/euclidean_rhythm_generator_test.sv
